@@ rtl/csf_pkg.sv @@
`timescale 1ns / 1ps
// csf_pkg: shared types, constants and header helpers for the chunk stream framer
// no dependencies; imported by csf_builder, csf_emitter, chunk_stream_framer_unit and the testbench
package csf_pkg;

  localparam int unsigned MAX_BYTES   = 18;
  localparam int unsigned BODY_BYTES  = 15;
  localparam int unsigned CNT_W       = $clog2(MAX_BYTES + 1);

  localparam logic [23:0] CHUNK_SIZE_RESET = 24'd128;
  localparam logic [23:0] TS_CLAMP         = 24'hffffff;
  localparam logic [31:0] EXT_TS_MIN       = 32'h00ffffff;
  localparam logic [16:0] ID_2BYTE         = 17'd64;
  localparam logic [16:0] ID_3BYTE         = 17'd319;

  localparam logic [1:0] FMT_FULL = 2'd0;
  localparam logic [1:0] FMT_CONT = 2'd3;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_PAYLOAD = 1'b1
  } csf_cmd_t;

  typedef logic [MAX_BYTES-1:0][7:0]  burst_bytes_t;
  typedef logic [BODY_BYTES-1:0][7:0] body_bytes_t;

  // everything one input word turns into; byte 0 goes out first
  typedef struct packed {
    burst_bytes_t       bytes;
    logic [CNT_W-1:0]   count;
    logic               err;
  } burst_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      len;
  } basic_hdr_t;

  function automatic basic_hdr_t csf_basic_hdr(input logic [1:0] fmt, input logic [16:0] id);
    basic_hdr_t h;
    logic [16:0] v;
    v = id - ID_2BYTE;
    h.bytes = '0;
    if (id >= ID_3BYTE) begin
      h.bytes[0] = {fmt, 6'd1};
      h.bytes[1] = v[7:0];
      h.bytes[2] = v[15:8];
      h.len = 2'd3;
    end else if (id >= ID_2BYTE) begin
      h.bytes[0] = {fmt, 6'd0};
      h.bytes[1] = v[7:0];
      h.len = 2'd2;
    end else begin
      h.bytes[0] = {fmt, id[5:0]};
      h.len = 2'd1;
    end
    return h;
  endfunction

  // basic header first, body right behind it
  function automatic burst_bytes_t csf_place(input logic [2:0][7:0] hdr, input logic [1:0] hlen,
                                             input body_bytes_t body);
    burst_bytes_t o;
    logic [4:0] j;
    o = '0;
    for (int i = 0; i < MAX_BYTES; i++) begin
      j = 5'(i) - {3'd0, hlen};
      if (5'(i) < {3'd0, hlen}) begin
        o[i] = hdr[i[1:0]];
      end else if (j < 5'(BODY_BYTES)) begin
        o[i] = body[j[3:0]];
      end
    end
    return o;
  endfunction

endpackage

@@ rtl/csf_builder.sv @@
`timescale 1ns / 1ps
// csf_builder: message state, chunk size register and per-word burst assembly
// depends on csf_pkg
module csf_builder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [23:0]          cfg_wr_data,
  input  logic                 in_fire,
  input  logic                 in_command,
  input  logic [16:0]          in_chunk_stream_id,
  input  logic [31:0]          in_msg_timestamp,
  input  logic [23:0]          in_msg_length,
  input  logic [7:0]           in_msg_type,
  input  logic [31:0]          in_msg_stream_id,
  input  logic [7:0]           in_payload_byte,
  output csf_pkg::burst_t      burst
);
  import csf_pkg::*;

  logic [23:0] chunk_size_r;
  logic        open_r, open_nxt;
  logic [16:0] cur_id_r, cur_id_nxt;
  logic [31:0] cur_ts_r, cur_ts_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [23:0] bic_r, bic_nxt;

  logic [23:0] size;
  logic        start_ext, cur_ext, new_chunk;
  logic [23:0] tsf;
  basic_hdr_t  hdr_start, hdr_cont;
  body_bytes_t body;
  logic [1:0]  hlen;

  always_comb begin
    size      = (chunk_size_r == '0) ? 24'd1 : chunk_size_r;
    start_ext = in_msg_timestamp >= EXT_TS_MIN;
    cur_ext   = cur_ts_r >= EXT_TS_MIN;
    tsf       = start_ext ? TS_CLAMP : in_msg_timestamp[23:0];
    new_chunk = bic_r >= size;
    hdr_start = csf_basic_hdr(FMT_FULL, in_chunk_stream_id);
    hdr_cont  = csf_basic_hdr(FMT_CONT, cur_id_r);

    open_nxt   = open_r;
    cur_id_nxt = cur_id_r;
    cur_ts_nxt = cur_ts_r;
    rem_nxt    = rem_r;
    bic_nxt    = bic_r;
    body       = '0;
    hlen       = 2'd0;
    burst      = '0;

    unique case (csf_cmd_t'(in_command))
      CMD_START: begin
        body[0]  = tsf[23:16];
        body[1]  = tsf[15:8];
        body[2]  = tsf[7:0];
        body[3]  = in_msg_length[23:16];
        body[4]  = in_msg_length[15:8];
        body[5]  = in_msg_length[7:0];
        body[6]  = in_msg_type;
        body[7]  = in_msg_stream_id[7:0];
        body[8]  = in_msg_stream_id[15:8];
        body[9]  = in_msg_stream_id[23:16];
        body[10] = in_msg_stream_id[31:24];
        if (start_ext) begin
          body[11] = in_msg_timestamp[31:24];
          body[12] = in_msg_timestamp[23:16];
          body[13] = in_msg_timestamp[15:8];
          body[14] = in_msg_timestamp[7:0];
        end
        burst.bytes = csf_place(hdr_start.bytes, hdr_start.len, body);
        burst.count = CNT_W'(hdr_start.len) + CNT_W'(11) + (start_ext ? CNT_W'(4) : '0);
        open_nxt    = 1'b1;
        cur_id_nxt  = in_chunk_stream_id;
        cur_ts_nxt  = in_msg_timestamp;
        rem_nxt     = in_msg_length;
        bic_nxt     = '0;
      end
      CMD_PAYLOAD: begin
        if (!open_r || rem_r == '0) begin
          // dropped word: one flagged result, nothing sent
          burst.count = CNT_W'(1);
          burst.err   = 1'b1;
        end else begin
          if (new_chunk && cur_ext) begin
            body[0] = cur_ts_r[31:24];
            body[1] = cur_ts_r[23:16];
            body[2] = cur_ts_r[15:8];
            body[3] = cur_ts_r[7:0];
            body[4] = in_payload_byte;
          end else begin
            body[0] = in_payload_byte;
          end
          hlen        = new_chunk ? hdr_cont.len : 2'd0;
          burst.bytes = csf_place(hdr_cont.bytes, hlen, body);
          burst.count = CNT_W'(hlen) + ((new_chunk && cur_ext) ? CNT_W'(5) : CNT_W'(1));
          bic_nxt     = new_chunk ? 24'd1 : bic_r + 24'd1;
          rem_nxt     = rem_r - 24'd1;
          open_nxt    = rem_r != 24'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_size_r <= CHUNK_SIZE_RESET;
      open_r       <= 1'b0;
      cur_id_r     <= '0;
      cur_ts_r     <= '0;
      rem_r        <= '0;
      bic_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        chunk_size_r <= cfg_wr_data;
      end
      if (in_fire) begin
        open_r   <= open_nxt;
        cur_id_r <= cur_id_nxt;
        cur_ts_r <= cur_ts_nxt;
        rem_r    <= rem_nxt;
        bic_r    <= bic_nxt;
      end
    end
  end

endmodule

@@ rtl/csf_emitter.sv @@
`timescale 1ns / 1ps
// csf_emitter: holds one burst and plays it out a byte per cycle, while out_ready allows, into the output register
// depends on csf_pkg
module csf_emitter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              burst_load,
  input  csf_pkg::burst_t   burst_in,
  output logic              take_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_byte_valid,
  output logic              out_error,
  output logic              out_last
);
  import csf_pkg::*;

  burst_t             burst_r;
  logic               full_r;
  logic [CNT_W-1:0]   idx_r;
  logic               ovalid_r;
  logic [7:0]         obyte_r;
  logic               obv_r, oerr_r, olast_r;

  logic               last_pos, out_load;

  always_comb begin
    last_pos = idx_r == (burst_r.count - CNT_W'(1));
    out_load = full_r && (!ovalid_r || out_ready);
    // burst slot frees as its last byte moves to the output register
    take_ok  = !full_r || (out_load && last_pos);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r   <= 1'b0;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
      if (burst_load) begin
        full_r <= 1'b1;
        idx_r  <= '0;
      end else if (out_load && last_pos) begin
        full_r <= 1'b0;
      end else if (out_load) begin
        idx_r <= idx_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (burst_load) begin
      burst_r <= burst_in;
    end
    if (out_load) begin
      obyte_r <= burst_r.bytes[idx_r];
      obv_r   <= !burst_r.err;
      oerr_r  <= burst_r.err;
      olast_r <= last_pos;
    end
  end

  assign out_valid      = ovalid_r;
  assign out_byte       = obyte_r;
  assign out_byte_valid = obv_r;
  assign out_error      = oerr_r;
  assign out_last       = olast_r;

endmodule

@@ rtl/chunk_stream_framer_unit.sv @@
`timescale 1ns / 1ps
// chunk_stream_framer_unit: top level of the chunk stream framer
// depends on csf_pkg, csf_builder, csf_emitter
//
//   channel  | handshake              | carries
//   ---------+------------------------+------------------------------------------
//   in_      | in_valid / in_ready    | command, header fields, payload byte
//   out_     | out_valid / out_ready  | out_byte, byte_valid, error, last
//   cfg_     | cfg_wr_en              | chunk size, 24 bits
//
// each accepted word is turned into a burst of 1 to 18 bytes in the cycle it is taken;
// the burst register then feeds the output register one byte per cycle while out_ready allows
// a payload word with no chunk header is a one-byte burst, so such words stream at one a cycle while out_ready is high
// a start word or a chunk boundary holds the input until the last byte of its burst moves to the output register
// reset is synchronous and active low; chunk size returns to 128, no message open
// out_ready low stalls the output register and, once the burst is waiting, the input
module chunk_stream_framer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [16:0] in_chunk_stream_id,
  input  logic [31:0] in_msg_timestamp,
  input  logic [23:0] in_msg_length,
  input  logic [7:0]  in_msg_type,
  input  logic [31:0] in_msg_stream_id,
  input  logic [7:0]  in_payload_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_error,
  output logic        out_last
);
  import csf_pkg::*;

  logic   in_fire;
  burst_t burst;

  assign in_fire = in_valid && in_ready;

  csf_builder u_builder (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_fire            (in_fire),
    .in_command         (in_command),
    .in_chunk_stream_id (in_chunk_stream_id),
    .in_msg_timestamp   (in_msg_timestamp),
    .in_msg_length      (in_msg_length),
    .in_msg_type        (in_msg_type),
    .in_msg_stream_id   (in_msg_stream_id),
    .in_payload_byte    (in_payload_byte),
    .burst              (burst)
  );

  csf_emitter u_emitter (
    .clk            (clk),
    .rst_n          (rst_n),
    .burst_load     (in_fire),
    .burst_in       (burst),
    .take_ok        (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_error      (out_error),
    .out_last       (out_last)
  );

`ifndef SYNTHESIS
  a_drop_single : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && burst.err |-> burst.count == CNT_W'(1))
    else $error("dropped word must give exactly one result");

  a_start_len : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_command == CMD_START |->
      burst.count >= CNT_W'(12) && burst.count <= CNT_W'(MAX_BYTES))
    else $error("start burst length out of range");

  a_err_form : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last && !out_byte_valid && out_byte == 8'd0)
    else $error("error result malformed");

  a_payload_len : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_command == CMD_PAYLOAD |->
      burst.count >= CNT_W'(1) && burst.count <= CNT_W'(8))
    else $error("payload burst length out of range");
`endif

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for chunk_stream_framer_unit, predicts every output word
// depends on csf_pkg and the framer rtl; stimulus and checking live in this one file
module testbench;
  import csf_pkg::*;

  class chunk_byte_scoreboard;
    typedef struct {
      logic [7:0] data;
      logic       valid;
      logic       err;
      logic       last;
    } beat_t;

    beat_t       expected_bytes[$];
    logic [23:0] chunk_size;
    bit          msg_open;
    logic [16:0] stream_id;
    logic [31:0] stamp;
    logic [23:0] remaining;
    logic [23:0] in_chunk;
    int          mismatches;
    int          words_seen;
    int          bytes_checked;
    int          dropped;
    int          cont_headers;
    int          ext_stamps;

    function new();
      chunk_size = CHUNK_SIZE_RESET;
      msg_open   = 1'b0;
      stream_id  = '0;
      stamp      = '0;
      remaining  = '0;
      in_chunk   = '0;
    endfunction

    function void push_byte(logic [7:0] b);
      beat_t e;
      e.data  = b;
      e.valid = 1'b1;
      e.err   = 1'b0;
      e.last  = 1'b0;
      expected_bytes.push_back(e);
    endfunction

    function void push_basic_header(logic [1:0] fmt, logic [16:0] id);
      logic [16:0] off;
      off = id - ID_2BYTE;
      if (id >= ID_3BYTE) begin
        push_byte({fmt, 6'd1});
        push_byte(off[7:0]);
        push_byte(off[15:8]);
      end else if (id >= ID_2BYTE) begin
        push_byte({fmt, 6'd0});
        push_byte(off[7:0]);
      end else begin
        push_byte({fmt, id[5:0]});
      end
    endfunction

    function void push_ext_stamp(logic [31:0] ts);
      if (ts >= EXT_TS_MIN) begin
        ext_stamps++;
        push_byte(ts[31:24]);
        push_byte(ts[23:16]);
        push_byte(ts[15:8]);
        push_byte(ts[7:0]);
      end
    endfunction

    // works out every byte one accepted input word should produce
    function void note_word(csf_cmd_t cmd, logic [16:0] id, logic [31:0] ts, logic [23:0] len,
                            logic [7:0] typ, logic [31:0] sid, logic [7:0] pb);
      logic [23:0] ts_field;
      logic [23:0] limit;
      beat_t       tail;
      words_seen++;
      if (cmd == CMD_START) begin
        ts_field  = (ts < EXT_TS_MIN) ? ts[23:0] : TS_CLAMP;
        msg_open  = 1'b1;
        stream_id = id;
        stamp     = ts;
        remaining = len;
        in_chunk  = '0;
        push_basic_header(FMT_FULL, id);
        push_byte(ts_field[23:16]);
        push_byte(ts_field[15:8]);
        push_byte(ts_field[7:0]);
        push_byte(len[23:16]);
        push_byte(len[15:8]);
        push_byte(len[7:0]);
        push_byte(typ);
        push_byte(sid[7:0]);
        push_byte(sid[15:8]);
        push_byte(sid[23:16]);
        push_byte(sid[31:24]);
        push_ext_stamp(ts);
      end else if (!msg_open || remaining == '0) begin
        dropped++;
        tail.data  = 8'h00;
        tail.valid = 1'b0;
        tail.err   = 1'b1;
        tail.last  = 1'b0;
        expected_bytes.push_back(tail);
      end else begin
        limit = (chunk_size == '0) ? 24'd1 : chunk_size;
        if (in_chunk >= limit) begin
          cont_headers++;
          push_basic_header(FMT_CONT, stream_id);
          push_ext_stamp(stamp);
          in_chunk = '0;
        end
        push_byte(pb);
        in_chunk  = in_chunk + 24'd1;
        remaining = remaining - 24'd1;
        if (remaining == '0)
          msg_open = 1'b0;
      end
      tail = expected_bytes.pop_back();
      tail.last = 1'b1;
      expected_bytes.push_back(tail);
    endfunction

    function void check_byte(logic [7:0] data, logic valid, logic err, logic last);
      beat_t e;
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output word: byte %02h valid %b error %b last %b",
                   data, valid, err, last);
        return;
      end
      e = expected_bytes.pop_front();
      if (data !== e.data || valid !== e.valid || err !== e.err || last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on output word %0d: expected %02h/%b/%b/%b got %02h/%b/%b/%b",
                   bytes_checked, e.data, e.valid, e.err, e.last, data, valid, err, last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [23:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_command;
  logic [16:0] in_chunk_stream_id;
  logic [31:0] in_msg_timestamp;
  logic [23:0] in_msg_length;
  logic [7:0]  in_msg_type;
  logic [31:0] in_msg_stream_id;
  logic [7:0]  in_payload_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_error;
  logic        out_last;

  chunk_byte_scoreboard sb = new();
  bit          quiet;
  int          stall_left;
  int          open_left;
  int          settings_used;
  logic [23:0] size_plan [0:7];

  chunk_stream_framer_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_chunk_stream_id (in_chunk_stream_id),
    .in_msg_timestamp   (in_msg_timestamp),
    .in_msg_length      (in_msg_length),
    .in_msg_type        (in_msg_type),
    .in_msg_stream_id   (in_msg_stream_id),
    .in_payload_byte    (in_payload_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_error          (out_error),
    .out_last           (out_last)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // output side: take each word, then pick the next stall burst
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_byte(out_byte, out_byte_valid, out_error, out_last);
    if (stall_left == 0 && !quiet && rst_n && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 13);
    out_ready <= (stall_left == 0);
    if (stall_left > 0)
      stall_left--;
  end

  task automatic send_word(csf_cmd_t cmd, logic [16:0] id, logic [31:0] ts, logic [23:0] len,
                           logic [7:0] typ, logic [31:0] sid, logic [7:0] pb);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_command         <= cmd;
    in_chunk_stream_id <= id;
    in_msg_timestamp   <= ts;
    in_msg_length      <= len;
    in_msg_type        <= typ;
    in_msg_stream_id   <= sid;
    in_payload_byte    <= pb;
    do @(posedge clk); while (!in_ready);
    sb.note_word(cmd, id, ts, len, typ, sid, pb);
  endtask

  // unused header fields carry junk so their bits still toggle
  task automatic send_payload(logic [7:0] pb);
    send_word(CMD_PAYLOAD, 17'($urandom), $urandom, 24'($urandom), 8'($urandom), $urandom, pb);
  endtask

  task automatic send_start(logic [16:0] id, logic [31:0] ts, logic [23:0] len, logic [7:0] typ,
                            logic [31:0] sid);
    send_word(CMD_START, id, ts, len, typ, sid, 8'($urandom));
  endtask

  task automatic send_random_start(logic [23:0] len);
    logic [16:0] id;
    logic [31:0] ts;
    case ($urandom_range(0, 5))
      0: id = 17'($urandom_range(2, 63));
      1: id = 17'($urandom_range(64, 318));
      2: id = 17'($urandom_range(319, 65599));
      3: begin
        case ($urandom_range(0, 5))
          0: id = 17'd2;
          1: id = 17'd63;
          2: id = 17'd64;
          3: id = 17'd318;
          4: id = 17'd319;
          default: id = 17'd65599;
        endcase
      end
      4: id = 17'($urandom);
      default: id = 17'($urandom_range(0, 1));
    endcase
    case ($urandom_range(0, 4))
      0: ts = $urandom_range(0, 1000);
      1: ts = $urandom;
      2: ts = 32'h00fffffe + 32'($urandom_range(0, 2));
      3: ts = 32'hffffffff;
      default: ts = 32'($urandom_range(0, 24'hfffffe));
    endcase
    send_start(id, ts, len, 8'($urandom), $urandom);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_chunk_size(logic [23:0] size);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.chunk_size = size;
    settings_used++;
  endtask

  task automatic run_phase(int n);
    int sent;
    int len;
    int count;
    sent = 0;
    // finish the message left open across the size change
    repeat (open_left) begin
      send_payload(8'($urandom));
      sent++;
    end
    open_left = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) == 0) begin
        send_payload(8'($urandom));
        sent++;
      end else begin
        case ($urandom_range(0, 24))
          0: len = 0;
          1: len = $urandom_range(60, 140);
          default: len = $urandom_range(1, 20);
        endcase
        send_random_start(24'(len));
        sent++;
        case ($urandom_range(0, 9))
          0: count = $urandom_range(0, len);
          1: count = len + $urandom_range(1, 2);
          default: count = len;
        endcase
        repeat (count) send_payload(8'($urandom));
        sent += count;
      end
    end
    len = $urandom_range(4, 12);
    send_random_start(24'(len));
    repeat (len / 2) send_payload(8'($urandom));
    open_left = len - len / 2;
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    in_valid           <= 1'b0;
    in_command         <= CMD_START;
    in_chunk_stream_id <= '0;
    in_msg_timestamp   <= '0;
    in_msg_length      <= '0;
    in_msg_type        <= '0;
    in_msg_stream_id   <= '0;
    in_payload_byte    <= '0;
    out_ready          <= 1'b0;
    quiet      = 1'b0;
    stall_left = 0;
    open_left  = 0;
    size_plan  = '{24'hffffff, 24'd2, 24'd0, 24'd5, 24'd1, 24'd3, 24'd128, 24'd7};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_payload(8'h3c);                                   // nothing open yet
    send_start(17'd0, 32'd0, 24'd0, 8'h00, 32'h0);         // zero length message
    send_payload(8'hc3);
    send_start(17'd1, 32'h00fffffe, 24'd3, 8'hff, 32'hffffffff);
    send_payload(8'h00);
    send_payload(8'hff);
    send_payload(8'ha5);
    send_payload(8'h5a);                                   // past the declared length
    send_start(17'd63, 32'h00ffffff, 24'hffffff, 8'h12, 32'h12345678);
    send_payload(8'h81);
    send_start(17'd64, 32'hffffffff, 24'd2, 8'h09, 32'h89abcdef);
    send_payload(8'h7e);
    write_chunk_size(24'd1);
    // one byte per chunk: every byte after the first gets a format-3 header
    send_start(17'd318, 32'h01000000, 24'd3, 8'h14, 32'h00000001);
    repeat (3) send_payload(8'($urandom));
    send_start(ID_3BYTE, 32'd0, 24'd2, 8'h08, 32'h80000000);
    repeat (2) send_payload(8'($urandom));
    send_start(17'd65599, 32'h00abcdef, 24'd2, 8'h12, 32'h0000ffff);
    repeat (2) send_payload(8'($urandom));
    send_start(17'h1ffff, 32'hffffffff, 24'd2, 8'h01, 32'hffff0000);
    repeat (2) send_payload(8'($urandom));

    for (int i = 0; i < 8; i++) begin
      write_chunk_size(size_plan[i]);
      if (i == 7)
        quiet = 1'b1;
      run_phase(30);
    end

    drain();
    $display("%0d input words gave %0d output words: %0d dropped, %0d continuation headers",
             sb.words_seen, sb.bytes_checked, sb.dropped, sb.cont_headers);
    $display("%0d extended timestamps, %0d chunk size writes including 0 and the 24-bit maximum",
             sb.ext_stamps, settings_used);
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0)
      $display("PASS chunk_stream_framer_unit");
    else
      $display("FAIL chunk_stream_framer_unit");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL chunk_stream_framer_unit");
    $finish;
  end

endmodule
